@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/tru_pkg.sv @@
// types and constants shared by the tga rle unpacker files
`default_nettype none
package tru_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 12;
	localparam int LEN_W     = 8;
	localparam int MIN_WIDTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH_CODED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_TO_BOTTOM    = 3'd4;

	// pixel format codes
	localparam logic [1:0] FMT_GRAY  = 2'd0;
	localparam logic [1:0] FMT_RGB24 = 2'd1;
	localparam logic [1:0] FMT_RGB32 = 2'd2;

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
	localparam logic [7:0]  HDR_RUN_BIT  = 8'h80;
	localparam logic [7:0]  HDR_COUNT    = 8'h7F;

	typedef struct packed {
		logic take_byte;   // accepted byte is processed this cycle
		logic load_span;   // next span goes into the output register
	} tru_cmd_t;

	typedef struct packed {
		logic pixel_ready; // accepted byte completes a pixel
		logic last_span;   // span being produced ends this pixel
	} tru_sts_t;

	typedef struct packed {
		logic [31:0]        pixel_color;
		logic [COORD_W-1:0] row_index;
		logic [COORD_W-1:0] start_column;
		logic [LEN_W-1:0]   span_length;
		logic               last_span;
		logic               image_done;
	} span_t;

endpackage
`default_nettype wire

@@ rtl/tru_ifs.sv @@
// handshake interfaces for the byte input and the span output
`default_nettype none
interface tru_byte_if;
	import tru_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface tru_span_if;
	import tru_pkg::*;
	logic               valid;
	logic               ready;
	logic [31:0]        pixel_color;
	logic [COORD_W-1:0] row_index;
	logic [COORD_W-1:0] start_column;
	logic [LEN_W-1:0]   span_length;
	logic               last_span;
	logic               image_done;

	modport source (output valid, output pixel_color, output row_index,
		output start_column, output span_length, output last_span,
		output image_done, input ready);
	modport sink (input valid, input pixel_color, input row_index,
		input start_column, input span_length, input last_span,
		input image_done, output ready);
endinterface
`default_nettype wire

@@ rtl/tru_ctrl.sv @@
// controller: byte intake, span emission and output register valid
`default_nettype none
module tru_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire tru_pkg::tru_sts_t sts,
	output tru_pkg::tru_cmd_t     cmd
);
	import tru_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SPAN = 1'b1;

	logic state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free      = !out_valid_q || out_ready;
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.take_byte = in_valid && (state_q == ST_IDLE);
	assign cmd.load_span = (state_q == ST_SPAN) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take_byte && sts.pixel_ready) state_d = ST_SPAN;
			end
			ST_SPAN: begin
				if (cmd.load_span && sts.last_span) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_span) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/tru_datapath.sv @@
// datapath: configuration, pixel assembly, packet state, raster position, spans
`default_nettype none
module tru_datapath #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tru_pkg::tru_cmd_t              cmd,
	output tru_pkg::tru_sts_t                   sts,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           cfg_we,
	input  wire logic [tru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tru_pkg::CFG_W-1:0]      cfg_data,
	output tru_pkg::span_t                      span
);
	import tru_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CW = (DW > CFG_W) ? DW : CFG_W;
	localparam int SW = (DW > LEN_W) ? DW : LEN_W;

	// configuration
	logic [1:0]       fmt_q;
	logic             rlc_q;
	logic [CFG_W-1:0] wid_q;
	logic [CFG_W-1:0] hgt_q;
	logic             ttb_q;

	// decode state
	logic [1:0]       bip_q;
	logic [31:0]      acc_q;
	logic             await_q;
	logic             run_q;
	logic [LEN_W-1:0] pleft_q;
	logic [DW-1:0]    col_q;
	logic [DW-1:0]    row_q;
	logic             fin_q;
	logic [31:0]      colour_q;
	logic [LEN_W-1:0] left_q;
	span_t            span_q;

	logic [CW-1:0]    wid_c, hgt_c;
	logic [DW-1:0]    w_eff, h_eff;

	// byte intake
	logic             col_ge;
	logic [DW-1:0]    row_w, col_w;
	logic             stop;
	logic             is_header;
	logic [31:0]      acc_or;
	logic             px_done;
	logic [31:0]      colour_c;
	logic [LEN_W-1:0] pleft_c;
	logic [LEN_W-1:0] count_c;
	logic             await_c;
	logic             pix_rdy_c;

	// span step
	logic [DW-1:0]    room;
	logic [LEN_W-1:0] take;
	logic [SW-1:0]    col_sum;
	logic [DW-1:0]    row_inc;
	logic             wrap_s;
	logic             done_s;
	logic [LEN_W-1:0] left_n;
	logic [DW-1:0]    row_dst;
	logic             last_c;

	// effective dimensions after clamping
	always_comb begin
		wid_c = CW'(wid_q);
		hgt_c = CW'(hgt_q);
		if (wid_c < CW'(MIN_WIDTH)) begin
			w_eff = DW'(MIN_WIDTH);
		end else if (wid_c > CW'(MAX_DIM)) begin
			w_eff = DW'(MAX_DIM);
		end else begin
			w_eff = DW'(wid_c);
		end
		if (hgt_c == '0) begin
			h_eff = DW'(1);
		end else if (hgt_c > CW'(MAX_DIM)) begin
			h_eff = DW'(MAX_DIM);
		end else begin
			h_eff = DW'(hgt_c);
		end
	end

	// intake of one byte
	always_comb begin
		col_ge    = (col_q >= w_eff);
		row_w     = col_ge ? row_q + DW'(1) : row_q;
		col_w     = col_ge ? '0 : col_q;
		stop      = (row_w >= h_eff);
		is_header = rlc_q && await_q;
		acc_or    = acc_q | (32'(data_byte) << {bip_q, 3'b000});

		unique case (fmt_q)
			FMT_GRAY:  px_done = 1'b1;
			FMT_RGB24: px_done = (bip_q >= 2'd2);
			default:   px_done = (bip_q == 2'd3);
		endcase

		unique case (fmt_q)
			FMT_GRAY:  colour_c = ALPHA_OPAQUE | {8'h00, acc_or[7:0], acc_or[7:0], acc_or[7:0]};
			FMT_RGB24: colour_c = ALPHA_OPAQUE | {8'h00, acc_or[23:0]};
			default:   colour_c = acc_or;
		endcase

		pleft_c = pleft_q;
		count_c = LEN_W'(1);
		if (rlc_q) begin
			if (run_q) begin
				count_c = pleft_q;
				pleft_c = '0;
			end else if (pleft_q != '0) begin
				pleft_c = pleft_q - LEN_W'(1);
			end
			if (count_c == '0) count_c = LEN_W'(1);
		end
		await_c = await_q || (rlc_q && (pleft_c == '0));

		pix_rdy_c = !fin_q && !stop && !is_header && px_done;
	end

	// one span per step, split at the row end
	always_comb begin
		room    = w_eff - col_q;
		take    = (SW'(left_q) < SW'(room)) ? left_q : LEN_W'(room);
		col_sum = SW'(col_q) + SW'(take);
		row_inc = row_q + DW'(1);
		wrap_s  = (col_sum >= SW'(w_eff));
		done_s  = wrap_s && (row_inc >= h_eff);
		left_n  = left_q - take;
		row_dst = ttb_q ? row_q : h_eff - DW'(1) - row_q;
		last_c  = (left_n == '0) || done_s;
	end

	assign sts.pixel_ready = pix_rdy_c;
	assign sts.last_span   = last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_RGB24;
			rlc_q   <= 1'b0;
			wid_q   <= CFG_W'(4);
			hgt_q   <= CFG_W'(1);
			ttb_q   <= 1'b0;
			bip_q   <= '0;
			acc_q   <= '0;
			await_q <= 1'b1;
			run_q   <= 1'b0;
			pleft_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PIXEL_FORMAT:     fmt_q <= cfg_data[1:0];
					REG_RUN_LENGTH_CODED: rlc_q <= cfg_data[0];
					REG_IMAGE_WIDTH:      wid_q <= cfg_data;
					REG_IMAGE_HEIGHT:     hgt_q <= cfg_data;
					REG_TOP_TO_BOTTOM:    ttb_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take_byte && !fin_q) begin
				col_q <= col_w;
				row_q <= row_w;
				if (stop) begin
					fin_q <= 1'b1;
				end else if (is_header) begin
					run_q   <= |(data_byte & HDR_RUN_BIT);
					pleft_q <= LEN_W'(data_byte & HDR_COUNT) + LEN_W'(1);
					await_q <= 1'b0;
					bip_q   <= '0;
					acc_q   <= '0;
				end else if (!px_done) begin
					acc_q <= acc_or;
					bip_q <= bip_q + 2'd1;
				end else begin
					acc_q   <= '0;
					bip_q   <= '0;
					pleft_q <= pleft_c;
					await_q <= await_c;
				end
			end
			if (cmd.load_span) begin
				if (wrap_s) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= DW'(col_sum);
				end
				if (done_s) fin_q <= 1'b1;
			end
		end
	end

	// pending pixel and output payload
	always_ff @(posedge clk) begin
		if (cmd.take_byte && pix_rdy_c) begin
			colour_q <= colour_c;
			left_q   <= count_c;
		end else if (cmd.load_span) begin
			left_q <= left_n;
		end
		if (cmd.load_span) begin
			span_q.pixel_color  <= colour_q;
			span_q.row_index    <= COORD_W'(row_dst);
			span_q.start_column <= COORD_W'(col_q);
			span_q.span_length  <= take;
			span_q.last_span    <= last_c;
			span_q.image_done   <= done_s;
		end
	end

	assign span = span_q;
endmodule
`default_nettype wire

@@ rtl/tga_rle_pixel_unpacker.sv @@
// top level of the tga rle pixel unpacker
`default_nettype none
// Takes the pixel-data bytes of a TGA image one item at a time (8-bit gray,
// 24-bit or 32-bit pixels, raw or run-length packets) and gives horizontal
// spans of one colour with their destination row, start column and length.
// A byte that does not complete a pixel (a packet header, an inner colour
// byte, or any byte after the final pixel) leaves the block idle, so such
// bytes stream at one per cycle. A byte that completes a pixel produces one
// span, or for a run that crosses row ends up to one span per row touched
// (at most 33). Span emission is sequenced by the controller through a
// single output register, and input stays blocked until the last span of
// the pixel is loaded, which a stalled consumer holds back. Configuration
// goes through a plain write port (index 0 pixel_format, 1 run_length_coded,
// 2 image_width, 3 image_height, 4 top_to_bottom); the user must write it
// only while the block is idle; the block itself does not enforce it. After
// reset the block is ready at once; there is no clearing pass.
module tga_rle_pixel_unpacker #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tru_byte_if.sink                            in_ch,
	tru_span_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [tru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tru_pkg::CFG_W-1:0]      cfg_data
);
	import tru_pkg::*;

	tru_cmd_t cmd;   // controller to datapath
	tru_sts_t sts;   // datapath to controller
	span_t    span;  // registered output payload

	// controller: accepts bytes in idle, then walks the spans of a pixel
	tru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config registers, colour assembly, packets, raster position
	tru_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (in_ch.data_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.span      (span)
	);

	// output payload straight from the output register
	assign out_ch.pixel_color  = span.pixel_color;
	assign out_ch.row_index    = span.row_index;
	assign out_ch.start_column = span.start_column;
	assign out_ch.span_length  = span.span_length;
	assign out_ch.last_span    = span.last_span;
	assign out_ch.image_done   = span.image_done;
endmodule
`default_nettype wire

@@ rtl/tru_checker.sv @@
// port-level checker for the tga rle pixel unpacker, with its bind
`default_nettype none
`include "assert_macros.svh"
module tru_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] pixel_color,
	input wire logic [11:0] row_index,
	input wire logic [11:0] start_column,
	input wire logic [7:0]  span_length,
	input wire logic        last_span,
	input wire logic        image_done
);
	logic [65:0] payload;

	assign payload = {pixel_color, row_index, start_column, span_length, last_span,
		image_done};

	// a stalled span holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload))

	// spans cover one to 128 pixels
	`ASSERT_IMPL(a_len_range, out_valid, (span_length != 8'd0) && (span_length <= 8'd128))

	// more spans of the same pixel pending, so no byte is taken
	`ASSERT_IMPL(a_block_input, out_valid && !last_span, !in_ready)

	// the span that ends the image ends its pixel
	`ASSERT_IMPL(a_done_last, out_valid && image_done, last_span)
endmodule

bind tga_rle_pixel_unpacker tru_checker u_tru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.pixel_color  (out_ch.pixel_color),
	.row_index    (out_ch.row_index),
	.start_column (out_ch.start_column),
	.span_length  (out_ch.span_length),
	.last_span    (out_ch.last_span),
	.image_done   (out_ch.image_done)
);
`default_nettype wire
